FILE: rtl/core/nfba_pkg.sv
// Shared types, codes and default sizes for the next-fit frame allocator.
package nfba_pkg;

   // Fixed field widths
   localparam int NUM_FRAMES_W = 13;
   localparam int ADDR_W       = 32;
   localparam int COUNT_W      = 5;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 32;

   // Default sizes
   localparam int DEF_MAX_FRAMES = 4096;
   localparam int DEF_PAGE_BITS  = 12;
   localparam int DEF_MAX_BATCH  = 16;

   // Register reset values
   localparam logic [NUM_FRAMES_W-1:0] NUM_FRAMES_RST = 13'd4096;
   localparam logic [ADDR_W-1:0]       USER_BASE_RST  = 32'h0100_0000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_FRAMES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_BASE  = 1'b1;

   // Request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FRAMES = 2'd1,
      STATUS_BAD_ADDR  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE,
      ST_START,
      ST_READ,
      ST_CHECK,
      ST_ROLL_RD,
      ST_ROLL_WR,
      ST_OUT_RD,
      ST_OUT_WR,
      ST_RESP
   } ctrl_state_type;

endpackage

FILE: rtl/core/nfba_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module nfba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/nfba_ctrl.sv
// Sequencer: clear pass, next-fit scan, rollback, free and result register.
module nfba_ctrl #(
   parameter int MAX_FRAMES = nfba_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_BITS  = nfba_pkg::DEF_PAGE_BITS,
   parameter int MAX_BATCH  = nfba_pkg::DEF_MAX_BATCH,
   parameter int IDX_W      = $clog2(MAX_FRAMES),
   parameter int CNT_W      = $clog2(MAX_FRAMES + 1),
   parameter int BI_W       = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   // active frame count and base
   input  logic [CNT_W-1:0]                 active_cnt,
   input  logic [nfba_pkg::ADDR_W-1:0]      user_base,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [nfba_pkg::COUNT_W-1:0]     req_count,
   input  logic [nfba_pkg::ADDR_W-1:0]      req_address,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [nfba_pkg::ADDR_W-1:0]      rsp_frame_address,
   output logic [nfba_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_last,
   // used-map RAM
   output logic                             map_wr_en,
   output logic [IDX_W-1:0]                 map_wr_addr,
   output logic                             map_wr_data,
   output logic [IDX_W-1:0]                 map_rd_addr,
   input  logic                             map_rd_data,
   // batch RAM
   output logic                             bat_wr_en,
   output logic [BI_W-1:0]                  bat_wr_addr,
   output logic [IDX_W-1:0]                 bat_wr_data,
   output logic [BI_W-1:0]                  bat_rd_addr,
   input  logic [IDX_W-1:0]                 bat_rd_data
);

   localparam int BC_W = $clog2(MAX_BATCH + 1);
   localparam int AW   = nfba_pkg::ADDR_W;

   nfba_pkg::ctrl_state_type state_ff, state_in;
   nfba_pkg::status_type     st_ff, st_in;

   logic [nfba_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]                addr_ff, addr_in;
   logic [IDX_W-1:0]             cursor_ff, cursor_in;
   logic [CNT_W-1:0]             probe_ff, probe_in;
   logic [BC_W-1:0]              got_ff, got_in;
   logic [BC_W-1:0]              idx_ff, idx_in;
   logic [IDX_W-1:0]             clr_ff, clr_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                rsp_addr_ff, rsp_addr_in;
   logic [nfba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         can_emit;
   logic [AW-1:0]                free_diff;
   logic [AW-1:0]                free_page;
   logic [CNT_W-1:0]             cursor_ext;
   logic [AW-1:0]                grant_addr;

   assign can_emit   = !rsp_valid_ff || !rsp_stall;
   assign free_diff  = addr_ff - user_base;
   assign free_page  = free_diff >> PAGE_BITS;
   assign cursor_ext = CNT_W'(cursor_ff);
   assign grant_addr = user_base + (AW'(bat_rd_data) << PAGE_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfba_pkg::ST_CLEAR;
         cursor_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      st_ff         <= st_in;
      cnt_ff        <= cnt_in;
      addr_ff       <= addr_in;
      probe_ff      <= probe_in;
      got_ff        <= got_in;
      idx_ff        <= idx_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      st_in         = st_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      cursor_in     = cursor_ff;
      probe_in      = probe_ff;
      got_in        = got_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      map_wr_en   = 1'b0;
      map_wr_addr = cursor_ff;
      map_wr_data = 1'b0;
      map_rd_addr = cursor_ff;
      bat_wr_en   = 1'b0;
      bat_wr_addr = got_ff[BI_W-1:0];
      bat_wr_data = cursor_ff;
      bat_rd_addr = idx_ff[BI_W-1:0];

      req_stall = (state_ff != nfba_pkg::ST_IDLE);

      case (state_ff)
         nfba_pkg::ST_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_ff;
            map_wr_data = 1'b0;
            clr_in      = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_FRAMES - 1)) begin
               state_in = nfba_pkg::ST_IDLE;
            end
         end

         nfba_pkg::ST_IDLE: begin
            if (req_valid) begin
               cnt_in  = req_count;
               addr_in = req_address;
               got_in  = '0;
               if (req_opcode == nfba_pkg::OP_FREE) begin
                  state_in = nfba_pkg::ST_FREE;
               end else if (req_count == '0) begin
                  st_in    = nfba_pkg::STATUS_OK;
                  state_in = nfba_pkg::ST_RESP;
               end else if (32'(req_count) > 32'(MAX_BATCH)) begin
                  st_in    = nfba_pkg::STATUS_NO_FRAMES;
                  state_in = nfba_pkg::ST_RESP;
               end else begin
                  state_in = nfba_pkg::ST_START;
               end
            end
         end

         nfba_pkg::ST_FREE: begin
            if ((addr_ff < user_base) || (free_page >= AW'(active_cnt))) begin
               st_in = nfba_pkg::STATUS_BAD_ADDR;
            end else begin
               st_in       = nfba_pkg::STATUS_OK;
               map_wr_en   = 1'b1;
               map_wr_addr = free_page[IDX_W-1:0];
               map_wr_data = 1'b0;
            end
            state_in = nfba_pkg::ST_RESP;
         end

         // new scan for one frame: wrap a stale cursor, reset probe count
         nfba_pkg::ST_START: begin
            if (cursor_ext >= active_cnt) begin
               cursor_in = '0;
            end
            probe_in = '0;
            state_in = nfba_pkg::ST_READ;
         end

         nfba_pkg::ST_READ: begin
            if (probe_ff == active_cnt) begin
               idx_in   = '0;
               state_in = nfba_pkg::ST_ROLL_RD;
            end else begin
               map_rd_addr = cursor_ff;
               state_in    = nfba_pkg::ST_CHECK;
            end
         end

         nfba_pkg::ST_CHECK: begin
            probe_in = probe_ff + CNT_W'(1);
            if (cursor_ext + CNT_W'(1) == active_cnt) begin
               cursor_in = '0;
            end else begin
               cursor_in = cursor_ff + IDX_W'(1);
            end
            if (!map_rd_data) begin
               map_wr_en   = 1'b1;
               map_wr_addr = cursor_ff;
               map_wr_data = 1'b1;
               bat_wr_en   = 1'b1;
               bat_wr_addr = got_ff[BI_W-1:0];
               bat_wr_data = cursor_ff;
               got_in      = got_ff + BC_W'(1);
               if (32'(got_ff) + 32'd1 == 32'(cnt_ff)) begin
                  idx_in   = '0;
                  state_in = nfba_pkg::ST_OUT_RD;
               end else begin
                  state_in = nfba_pkg::ST_START;
               end
            end else begin
               state_in = nfba_pkg::ST_READ;
            end
         end

         // give back every frame taken so far
         nfba_pkg::ST_ROLL_RD: begin
            if (idx_ff == got_ff) begin
               st_in    = nfba_pkg::STATUS_NO_FRAMES;
               state_in = nfba_pkg::ST_RESP;
            end else begin
               bat_rd_addr = idx_ff[BI_W-1:0];
               state_in    = nfba_pkg::ST_ROLL_WR;
            end
         end

         nfba_pkg::ST_ROLL_WR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = bat_rd_data;
            map_wr_data = 1'b0;
            idx_in      = idx_ff + BC_W'(1);
            state_in    = nfba_pkg::ST_ROLL_RD;
         end

         nfba_pkg::ST_OUT_RD: begin
            bat_rd_addr = idx_ff[BI_W-1:0];
            state_in    = nfba_pkg::ST_OUT_WR;
         end

         nfba_pkg::ST_OUT_WR: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = grant_addr;
               rsp_status_in = nfba_pkg::STATUS_OK;
               rsp_last_in   = (32'(idx_ff) + 32'd1 == 32'(cnt_ff));
               idx_in        = idx_ff + BC_W'(1);
               if (32'(idx_ff) + 32'd1 == 32'(cnt_ff)) begin
                  state_in = nfba_pkg::ST_IDLE;
               end else begin
                  state_in = nfba_pkg::ST_OUT_RD;
               end
            end
         end

         nfba_pkg::ST_RESP: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = st_ff;
               rsp_last_in   = 1'b1;
               state_in      = nfba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = nfba_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

FILE: rtl/core/next_fit_bitmap_frame_allocator.sv
// Next-fit bitmap frame allocator: config registers, used map, batch list and sequencer.
// Zero or oversize counts go straight to the result; a free checks the address first; an allocate
//   scans the bitmap frame by frame, then reads back and emits each granted frame.
// Throughput: one request at a time, the next taken the cycle after the last result is
//   registered; each probe reads one map bit and checks it, and probes set scan time.
// Reset: synchronous; afterwards a clearing pass writes every used-map bit with
//   req_stall high; config writes are taken throughout.
module next_fit_bitmap_frame_allocator #(
   parameter int MAX_FRAMES = nfba_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_BITS  = nfba_pkg::DEF_PAGE_BITS,
   parameter int MAX_BATCH  = nfba_pkg::DEF_MAX_BATCH
) (
   input  logic                                clock,
   input  logic                                reset,
   // config write port
   input  logic                                csr_we,
   input  logic [nfba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nfba_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [nfba_pkg::COUNT_W-1:0]        req_count,
   input  logic [nfba_pkg::ADDR_W-1:0]         req_address,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nfba_pkg::ADDR_W-1:0]         rsp_frame_address,
   output logic [nfba_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_last
);

   localparam int IDX_W = $clog2(MAX_FRAMES);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int BI_W  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

   logic [nfba_pkg::NUM_FRAMES_W-1:0] num_frames_ff, num_frames_in;
   logic [nfba_pkg::ADDR_W-1:0]       user_base_ff, user_base_in;
   logic [CNT_W-1:0]                  active_cnt;

   logic             map_wr_en;
   logic [IDX_W-1:0] map_wr_addr;
   logic             map_wr_data;
   logic [IDX_W-1:0] map_rd_addr;
   logic             map_rd_data;

   logic             bat_wr_en;
   logic [BI_W-1:0]  bat_wr_addr;
   logic [IDX_W-1:0] bat_wr_data;
   logic [BI_W-1:0]  bat_rd_addr;
   logic [IDX_W-1:0] bat_rd_data;

   // config registers
   always_comb begin
      num_frames_in = num_frames_ff;
      user_base_in  = user_base_ff;
      if (csr_we) begin
         case (csr_index)
            nfba_pkg::CSR_NUM_FRAMES: begin
               num_frames_in = csr_wdata[nfba_pkg::NUM_FRAMES_W-1:0];
            end
            nfba_pkg::CSR_USER_BASE: begin
               user_base_in = csr_wdata[nfba_pkg::ADDR_W-1:0];
            end
            default: begin
               num_frames_in = num_frames_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_frames_ff <= nfba_pkg::NUM_FRAMES_RST;
         user_base_ff  <= nfba_pkg::USER_BASE_RST;
      end else begin
         num_frames_ff <= num_frames_in;
         user_base_ff  <= user_base_in;
      end
   end

   // active count is num_frames clamped to the map size
   assign active_cnt = (32'(num_frames_ff) < 32'(MAX_FRAMES)) ?
                       CNT_W'(num_frames_ff) : CNT_W'(MAX_FRAMES);

   // one bit per frame: 1 = used
   nfba_ram #(
      .WIDTH (1),
      .DEPTH (MAX_FRAMES),
      .AW    (IDX_W)
   ) u_used_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // frames taken by the request in flight
   nfba_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_BATCH),
      .AW    (BI_W)
   ) u_batch (
      .clock   (clock),
      .wr_en   (bat_wr_en),
      .wr_addr (bat_wr_addr),
      .wr_data (bat_wr_data),
      .rd_addr (bat_rd_addr),
      .rd_data (bat_rd_data)
   );

   nfba_ctrl #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .MAX_BATCH  (MAX_BATCH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .BI_W       (BI_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .active_cnt        (active_cnt),
      .user_base         (user_base_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_count         (req_count),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_address (rsp_frame_address),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .map_wr_en         (map_wr_en),
      .map_wr_addr       (map_wr_addr),
      .map_wr_data       (map_wr_data),
      .map_rd_addr       (map_rd_addr),
      .map_rd_data       (map_rd_data),
      .bat_wr_en         (bat_wr_en),
      .bat_wr_addr       (bat_wr_addr),
      .bat_wr_data       (bat_wr_data),
      .bat_rd_addr       (bat_rd_addr),
      .bat_rd_data       (bat_rd_data)
   );

endmodule

FILE: dv/tb_next_fit_bitmap_frame_allocator.sv
// Self-checking testbench for the next-fit bitmap frame allocator: directed and random requests.
module tb_next_fit_bitmap_frame_allocator;
   import nfba_pkg::*;

   localparam int MAX_FRAMES     = DEF_MAX_FRAMES;
   localparam int PAGE_BITS      = DEF_PAGE_BITS;
   localparam int MAX_BATCH      = DEF_MAX_BATCH;
   // worst legal request: 16 frames scanned over 4096 bits, each probe a read and a check,
   // plus the clearing pass and a long receiver hold-off, taken about three times over
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic               opcode;
      logic [COUNT_W-1:0] count;
      logic [ADDR_W-1:0]  address;
   } frame_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] frame_address;
      status_type        status;
      logic              last;
   } grant_type;

   // DUT ports; every input starts at a known value
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_NUM_FRAMES;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;
   logic                  req_valid   = 1'b0;
   logic                  req_opcode  = OP_ALLOC;
   logic [COUNT_W-1:0]    req_count   = '0;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  rsp_stall   = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [ADDR_W-1:0]     rsp_frame_address;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_last;

   // predictor state: used bits, next-fit cursor, register copies, batch list
   bit [MAX_FRAMES-1:0]   frame_used;
   int unsigned           scan_cursor;
   logic [NUM_FRAMES_W-1:0] cfg_frames;
   logic [ADDR_W-1:0]     cfg_base;
   int unsigned           batch_list [MAX_BATCH];

   frame_req_type         req_backlog [$];   // requests waiting for the driver
   grant_type             grants_due [$];    // predicted results, oldest first

   int unsigned           reqs_queued   = 0;
   int unsigned           reqs_accepted = 0;
   int unsigned           error_count   = 0;
   int unsigned           quiet_cycles  = 0;
   int unsigned           sender_idle_pct    = 0;
   int unsigned           receiver_stall_pct = 0;
   int unsigned           hold_requests = 0;
   int unsigned           holds_served  = 0;
   int unsigned           hold_left     = 0;
   int unsigned           phase_frames;
   logic [ADDR_W-1:0]     phase_base;
   bit                    req_accepted  = 1'b0;

   next_fit_bitmap_frame_allocator u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_count         (req_count),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_address (rsp_frame_address),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // frames tracked; register values above the map size saturate
   function automatic int unsigned active_frames();
      return (cfg_frames < MAX_FRAMES) ? int'(cfg_frames) : MAX_FRAMES;
   endfunction

   // one lap of the ring from the cursor; the cursor moves on every probe,
   // so a lap that finds nothing leaves it where it started
   function automatic bit claim_next_frame(input int unsigned n, output int unsigned frame);
      int unsigned i;
      int unsigned probe;
      if (scan_cursor >= n) scan_cursor = 0;   // map shrank under the cursor
      for (i = 0; i < n; i++) begin
         probe = scan_cursor;
         scan_cursor = (probe + 1 == n) ? 0 : probe + 1;
         if (!frame_used[probe]) begin
            frame_used[probe] = 1'b1;
            frame = probe;
            return 1'b1;
         end
      end
      frame = 0;
      return 1'b0;
   endfunction

   function automatic void push_grant(input logic [ADDR_W-1:0] addr, input status_type st,
                                      input logic last);
      grant_type g;
      g.frame_address = addr;
      g.status        = st;
      g.last          = last;
      grants_due.push_back(g);
   endfunction

   // work out every result of one accepted request and update the state
   function automatic void compute_grants(input frame_req_type r);
      int unsigned n;
      int unsigned got;
      int unsigned frame;
      int unsigned i;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] page;
      n = active_frames();
      if (r.opcode == OP_ALLOC) begin
         if (r.count == 0) begin
            push_grant('0, STATUS_OK, 1'b1);
         end else if (r.count > MAX_BATCH) begin
            push_grant('0, STATUS_NO_FRAMES, 1'b1);       // oversize batch, state untouched
         end else begin
            got = 0;
            for (i = 0; i < r.count; i++) begin
               if (!claim_next_frame(n, frame)) break;
               batch_list[i] = frame;
               got++;
            end
            if (got != r.count) begin
               // ran dry: give back what this request took, cursor stays advanced
               for (i = 0; i < got; i++) frame_used[batch_list[i]] = 1'b0;
               push_grant('0, STATUS_NO_FRAMES, 1'b1);
            end else begin
               for (i = 0; i < got; i++) begin
                  page = batch_list[i];
                  push_grant(cfg_base + (page << PAGE_BITS), STATUS_OK, i + 1 == got);
               end
            end
         end
      end else begin
         offset = r.address - cfg_base;
         if (r.address < cfg_base || (offset >> PAGE_BITS) >= n) begin
            push_grant('0, STATUS_BAD_ADDR, 1'b1);
         end else begin
            frame_used[offset >> PAGE_BITS] = 1'b0;         // cleared even if already free
            push_grant('0, STATUS_OK, 1'b1);
         end
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic push_req(input logic op, input int unsigned count,
                           input logic [ADDR_W-1:0] address);
      frame_req_type r;
      r.opcode  = op;
      // the field the opcode ignores carries noise
      r.count   = (op == OP_ALLOC) ? count[COUNT_W-1:0] : COUNT_W'($urandom);
      r.address = (op == OP_FREE) ? address : ADDR_W'($urandom);
      req_backlog.push_back(r);
      reqs_queued++;
   endtask

   // mostly sized to the map so batches both fit and run dry, plus some noise
   function automatic frame_req_type random_request(input int unsigned n,
                                                    input logic [ADDR_W-1:0] base);
      frame_req_type r;
      int unsigned pick;
      int unsigned max_count;
      int unsigned frame;
      r.count   = COUNT_W'($urandom);
      r.address = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.opcode  = OP_ALLOC;
         max_count = (n >= 32) ? MAX_BATCH : ((n >= 2) ? n / 2 : 1);
         pick = $urandom_range(0, 99);
         if (pick < 6)       r.count = '0;
         else if (pick < 86) r.count = COUNT_W'($urandom_range(1, max_count));
         else if (pick < 94) r.count = COUNT_W'($urandom_range(1, MAX_BATCH));
         else r.count = COUNT_W'($urandom_range(MAX_BATCH + 1, (1 << COUNT_W) - 1));
      end else begin
         r.opcode = OP_FREE;
         frame = (n == 0) ? 0 : $urandom_range(0, n - 1);
         pick = $urandom_range(0, 99);
         if (pick < 75)
            r.address = base + (frame << PAGE_BITS) + $urandom_range(0, (1 << PAGE_BITS) - 1);
         else if (pick < 83)
            r.address = base + (n << PAGE_BITS) + $urandom_range(0, (1 << PAGE_BITS) - 1);
         else if (pick < 91)
            r.address = base - 1 - $urandom_range(0, (1 << PAGE_BITS) - 1);
         else
            r.address = $urandom;
      end
      return r;
   endfunction

   task automatic fill_random(input int unsigned items);
      int unsigned n;
      int unsigned k;
      n = (phase_frames < MAX_FRAMES) ? phase_frames : MAX_FRAMES;
      for (k = 0; k < items; k++) begin
         req_backlog.push_back(random_request(n, phase_base));
         reqs_queued++;
      end
   endtask

   // every request taken and every predicted result seen
   task automatic wait_drained();
      while (reqs_accepted != reqs_queued || grants_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // registers only change with the block idle
   task automatic configure(input int unsigned frames, input logic [ADDR_W-1:0] base,
                            input int unsigned idle_pct, input int unsigned stall_pct);
      logic [CSR_DATA_W-1:0] data;
      wait_drained();
      data = $urandom;                       // bits above the register width are noise
      data[NUM_FRAMES_W-1:0] = frames[NUM_FRAMES_W-1:0];
      write_reg(CSR_NUM_FRAMES, data);
      write_reg(CSR_USER_BASE, base);
      phase_frames       = frames;
      phase_base         = base;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset registers: 4096 frames at the default base
      push_req(OP_ALLOC, 0, '0);                             // empty batch
      push_req(OP_ALLOC, 1, '0);
      push_req(OP_ALLOC, MAX_BATCH, '0);                     // largest batch
      push_req(OP_ALLOC, MAX_BATCH + 1, '0);                 // oversize, rejected
      push_req(OP_ALLOC, (1 << COUNT_W) - 1, '0);
      push_req(OP_FREE, 0, USER_BASE_RST);
      push_req(OP_FREE, 0, USER_BASE_RST + 32'h0000_0fff);   // same frame, already free
      push_req(OP_FREE, 0, USER_BASE_RST - 1);               // just below base
      push_req(OP_FREE, 0, 32'h0000_0000);
      push_req(OP_FREE, 0, USER_BASE_RST + ((MAX_FRAMES - 1) << PAGE_BITS) + 32'h0000_0fff);
      push_req(OP_FREE, 0, USER_BASE_RST + (MAX_FRAMES << PAGE_BITS));   // one past the map
      push_req(OP_FREE, 0, 32'hffff_ffff);

      // shrink the map below the cursor; frames 1..3 still held
      configure(4, 32'hffff_d000, 0, 0);
      push_req(OP_ALLOC, 3, '0);                             // runs dry, rolled back
      push_req(OP_FREE, 0, 32'hffff_e000);
      push_req(OP_FREE, 0, 32'hffff_f123);
      push_req(OP_ALLOC, 3, '0);
      push_req(OP_ALLOC, 1, '0);                             // map full

      // empty map
      configure(0, 32'hffff_d000, 0, 0);
      push_req(OP_ALLOC, 1, '0);
      push_req(OP_ALLOC, 0, '0);
      push_req(OP_FREE, 0, 32'hffff_d000);

      // oversized register saturates; base near the top so addresses wrap
      configure((1 << NUM_FRAMES_W) - 1, 32'hffff_f000, 0, 0);
      push_req(OP_ALLOC, 2, '0);
      push_req(OP_FREE, 0, 32'hffff_f000);
      push_req(OP_ALLOC, MAX_BATCH, '0);

      // random phases; the sender pauses for a full drain midway through the first
      configure(16, $urandom, 0, 0);
      fill_random(20);
      wait_drained();
      fill_random(20);

      configure(8, 32'h0000_0000, 66, 0);
      fill_random(40);

      // long receiver hold-off while requests keep coming, so the input backs up
      configure(32, 32'hffff_ffff, 0, 66);
      hold_requests++;
      fill_random(40);

      configure(1, $urandom, 27, 27);
      fill_random(30);

      configure(MAX_FRAMES, USER_BASE_RST, 27, 27);
      fill_random(40);

      wait_drained();
      repeat (20) @(negedge clock);
      if (grants_due.size() != 0) begin
         error_count++;
         $display("%0d predicted results never arrived", grants_due.size());
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   // new request only once the previous one went through; payload held while stalled
   always @(negedge clock) begin : drive_requests
      frame_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_req = req_backlog.pop_front();
            req_valid   <= 1'b1;
            req_opcode  <= next_req.opcode;
            req_count   <= next_req.count;
            req_address <= next_req.address;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall, or a counted hold-off when one is asked for
   always @(negedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      grant_type     want;
      frame_req_type seen;
      if (reset) begin
         frame_used   = '0;
         scan_cursor  = 0;
         cfg_frames   = NUM_FRAMES_RST;
         cfg_base     = USER_BASE_RST;
         req_accepted = 1'b0;
         grants_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_NUM_FRAMES) cfg_frames = csr_wdata[NUM_FRAMES_W-1:0];
            else if (csr_index == CSR_USER_BASE) cfg_base = csr_wdata;
         end
         // results first, so a result never matches a request taken on the same edge
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected result: addr %h status %0d last %0b",
                           rsp_frame_address, rsp_status, rsp_last);
            end else begin
               want = grants_due.pop_front();
               if (rsp_frame_address !== want.frame_address || rsp_status !== want.status ||
                   rsp_last !== want.last) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("mismatch: expected addr %h status %0d last %0b, got %h %0d %0b",
                              want.frame_address, want.status, want.last,
                              rsp_frame_address, rsp_status, rsp_last);
               end
            end
         end
         req_accepted = req_valid && !req_stall;
         if (req_accepted) begin
            seen.opcode  = req_opcode;
            seen.count   = req_count;
            seen.address = req_address;
            compute_grants(seen);
            reqs_accepted++;
         end
      end
   end

   // watchdog on cycles with no request and no result moving
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

FILE: sim.f
rtl/core/nfba_pkg.sv
rtl/core/nfba_ram.sv
rtl/core/nfba_ctrl.sv
rtl/core/next_fit_bitmap_frame_allocator.sv
dv/tb_next_fit_bitmap_frame_allocator.sv
